// File: rtl/core/nmea_sentence_framer_top_defines.svh
// Assertion macros for the NMEA sentence framer.
`ifndef NMEA_SENTENCE_FRAMER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/nsf_pkg.sv
// Shared types and constants for the NMEA sentence framer.
package nsf_pkg;

  localparam int MAX_SENTENCE_DEF = 128;
  localparam int NUM_KINDS        = 5;
  localparam int HDR_LEN          = 5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [2:0] PH_HUNT      = 3'd0;
  localparam logic [2:0] PH_BODY      = 3'd1;
  localparam logic [2:0] PH_HEX1      = 3'd2;
  localparam logic [2:0] PH_HEX2      = 3'd3;
  localparam logic [2:0] PH_HEX2_DONE = 3'd4;
  localparam logic [2:0] PH_CR        = 3'd5;
  localparam logic [2:0] PH_LF        = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_CUT      = 3'd2;
  localparam logic [2:0] ST_BADTAIL  = 3'd3;
  localparam logic [2:0] ST_TOOLONG  = 3'd4;

  localparam logic [2:0] KIND_OTHER = 3'd0;

  localparam logic [7:0] KIND_NAMES [NUM_KINDS][HDR_LEN] = '{
    '{"G", "P", "G", "G", "A"},
    '{"G", "P", "G", "S", "A"},
    '{"G", "P", "G", "S", "V"},
    '{"G", "P", "R", "M", "C"},
    '{"G", "P", "V", "T", "G"}
  };

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] sentence_kind;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [7:0] sentence_length;
  } res_t;

endpackage

// File: rtl/core/nmea_sentence_framer_top.sv
// NMEA sentence framer: checksum, header kind and tail check per received byte.
// Takes one byte per cycle, with no bubbles, while in_stall is low. Each byte updates the sentence
// state in a single registered step; a sentence result is registered into the output
// register, or into the skid register while the output is held. A one-entry skid register
// sits behind the output register, so in_stall is raised only when both hold
// an unclaimed item; it is a registered signal with no path from out_stall.
`include "nmea_sentence_framer_top_defines.svh"

module nmea_sentence_framer_top #(
  parameter int MAX_SENTENCE = nsf_pkg::MAX_SENTENCE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [2:0] out_sentence_kind,
  output logic [7:0] out_computed_sum,
  output logic [7:0] out_received_sum,
  output logic [7:0] out_sentence_length
);
  import nsf_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_SENTENCE);

  logic [2:0]           phase_r, phase_nxt;
  logic [7:0]           xor_r, xor_nxt;
  logic [7:0]           cnt_r, cnt_nxt;
  logic [7:0]           hex_r, hex_nxt;
  logic [NUM_KINDS-1:0] hdr_r, hdr_nxt;

  logic                 out_valid_r, skid_valid_r;
  res_t                 out_r, skid_r;

  logic                 in_acc, out_take, emit, res_v;
  res_t                 res;
  logic [7:0]           cnt_inc;
  logic [NUM_KINDS-1:0] hdr_upd;
  logic [2:0]           pos;
  logic [4:0]           hd;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

  function automatic logic [2:0] kind_of(input logic [7:0] cnt,
                                         input logic [NUM_KINDS-1:0] m);
    logic [2:0] kd;
    kd = KIND_OTHER;
    if (cnt >= 8'(HDR_LEN + 1)) begin
      for (int k = NUM_KINDS - 1; k >= 0; k--) begin
        if (m[k]) kd = 3'(k + 1);
      end
    end
    return kd;
  endfunction

  assign out_take = out_valid_r & ~out_stall;
  assign in_acc   = in_valid & ~skid_valid_r;
  assign in_stall = skid_valid_r;

  always_comb begin
    cnt_inc = (cnt_r != 8'hFF) ? cnt_r + 8'd1 : cnt_r;
    pos     = 3'(cnt_inc - 8'd2);
    hdr_upd = hdr_r;
    if (cnt_inc >= 8'd2 && cnt_inc <= 8'(HDR_LEN + 1)) begin
      for (int k = 0; k < NUM_KINDS; k++) begin
        if (KIND_NAMES[k][pos] != in_data_byte) hdr_upd[k] = 1'b0;
      end
    end
    hd = hex_digit(in_data_byte);
  end

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    cnt_nxt   = cnt_r;
    hex_nxt   = hex_r;
    hdr_nxt   = hdr_r;
    emit      = 1'b0;
    res       = '0;
    if (phase_r == PH_HUNT) begin
      if (in_data_byte == CH_DOLLAR) begin
        phase_nxt = PH_BODY;
        xor_nxt   = 8'd0;
        cnt_nxt   = 8'd1;
        hex_nxt   = 8'd0;
        hdr_nxt   = '1;
      end
    end else if (in_data_byte == CH_DOLLAR) begin
      emit      = 1'b1;
      res       = '{ST_CUT, kind_of(cnt_r, hdr_r), xor_r, hex_r, cnt_r};
      phase_nxt = PH_BODY;
      xor_nxt   = 8'd0;
      cnt_nxt   = 8'd1;
      hex_nxt   = 8'd0;
      hdr_nxt   = '1;
    end else begin
      cnt_nxt = cnt_inc;
      hdr_nxt = hdr_upd;
      unique case (phase_r)
        PH_BODY: begin
          if (in_data_byte == CH_STAR) phase_nxt = PH_HEX1;
          else xor_nxt = xor_r ^ in_data_byte;
        end
        PH_HEX1: begin
          if (hd[4]) begin
            hex_nxt   = {4'd0, hd[3:0]};
            phase_nxt = PH_HEX2;
          end else begin
            hex_nxt   = 8'd0;
            phase_nxt = PH_HEX2_DONE;
          end
        end
        PH_HEX2: begin
          if (hd[4]) hex_nxt = {hex_r[3:0], hd[3:0]};
          phase_nxt = PH_CR;
        end
        PH_HEX2_DONE: phase_nxt = PH_CR;
        PH_CR: begin
          if (in_data_byte == CH_CR) begin
            phase_nxt = PH_LF;
          end else begin
            emit      = 1'b1;
            res       = '{ST_BADTAIL, kind_of(cnt_inc, hdr_upd), xor_r, hex_r, cnt_inc};
            phase_nxt = PH_HUNT;
          end
        end
        PH_LF: begin
          emit      = 1'b1;
          phase_nxt = PH_HUNT;
          if (in_data_byte != CH_LF)
            res = '{ST_BADTAIL, kind_of(cnt_inc, hdr_upd), xor_r, hex_r, cnt_inc};
          else if (xor_r == hex_r)
            res = '{ST_OK, kind_of(cnt_inc, hdr_upd), xor_r, hex_r, cnt_inc};
          else
            res = '{ST_MISMATCH, kind_of(cnt_inc, hdr_upd), xor_r, hex_r, cnt_inc};
        end
        default: phase_nxt = PH_HUNT;
      endcase
      if (!emit && phase_r <= PH_CR && cnt_inc >= MaxLen) begin
        emit      = 1'b1;
        cnt_nxt   = MaxLen;
        phase_nxt = PH_HUNT;
        res       = '{ST_TOOLONG, kind_of(MaxLen, hdr_upd), xor_nxt, hex_nxt, MaxLen};
      end
    end
  end

  assign res_v = in_acc & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      xor_r   <= 8'd0;
      cnt_r   <= 8'd0;
      hex_r   <= 8'd0;
      hdr_r   <= '1;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      cnt_r   <= cnt_nxt;
      hex_r   <= hex_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_v;
      end
    end else if (res_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (res_v) out_r <= res;
    end else if (res_v) begin
      skid_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_sentence_kind   = out_r.sentence_kind;
  assign out_computed_sum    = out_r.computed_sum;
  assign out_received_sum    = out_r.received_sum;
  assign out_sentence_length = out_r.sentence_length;

  `NSF_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r,
                  "skid holds an item while output register is empty")
  `NSF_ASSERT_NOW(a_len_in_range, phase_r != PH_HUNT,
                  cnt_r >= 8'd1 && cnt_r <= MaxLen, "byte count out of range")
  `NSF_ASSERT_NOW(a_toolong_len, out_valid_r && out_status == ST_TOOLONG,
                  out_sentence_length == MaxLen, "too-long item with wrong length")
  `NSF_ASSERT_NEXT(a_dollar_starts, in_acc && in_data_byte == CH_DOLLAR,
                   phase_r == PH_BODY && cnt_r == 8'd1, "dollar did not start a sentence")

endmodule

// File: sim/nsf_tb_pkg.sv
// Sentence report scoreboard for the NMEA framer testbench.
package nsf_tb_pkg;
  import nsf_pkg::*;

  class sentence_tracker;
    res_t       expected_q[$];
    int         mismatches;
    int         reports;
    int         status_seen[5];
    int         max_len;
    logic [2:0] phase;
    logic [7:0] xsum;
    logic [7:0] count;
    logic [7:0] hexv;
    logic [4:0] hdr_match;

    function new(int max_len_i);
      max_len     = max_len_i;
      mismatches  = 0;
      reports     = 0;
      status_seen = '{default: 0};
      phase       = PH_HUNT;
      xsum        = 8'h00;
      count       = 8'h00;
      hexv        = 8'h00;
      hdr_match   = '1;
    endfunction

    function void open_sentence();
      phase     = PH_BODY;
      xsum      = 8'h00;
      count     = 8'd1;
      hexv      = 8'h00;
      hdr_match = '1;
    endfunction

    function int nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void push_report(logic [2:0] status);
      res_t r;
      r.sentence_kind = KIND_OTHER;
      if (count >= 8'd6) begin
        for (int k = NUM_KINDS - 1; k >= 0; k--) begin
          if (hdr_match[k]) r.sentence_kind = 3'(k + 1);
        end
      end
      r.status          = status;
      r.computed_sum    = xsum;
      r.received_sum    = hexv;
      r.sentence_length = count;
      expected_q.push_back(r);
    endfunction

    function void accept_byte(logic [7:0] c);
      int d;
      if (phase == PH_HUNT) begin
        if (c == CH_DOLLAR) open_sentence();
        return;
      end
      if (c == CH_DOLLAR) begin
        push_report(ST_CUT);
        open_sentence();
        return;
      end
      if (count < 8'd255) count++;
      if (count >= 8'd2 && count <= 8'd6) begin
        for (int k = 0; k < NUM_KINDS; k++) begin
          if (KIND_NAMES[k][count - 2] != c) hdr_match[k] = 1'b0;
        end
      end
      case (phase)
        PH_BODY: begin
          if (c == CH_STAR) phase = PH_HEX1;
          else xsum ^= c;
        end
        PH_HEX1: begin
          d = nibble_of(c);
          if (d >= 0) begin
            hexv  = 8'(d);
            phase = PH_HEX2;
          end else begin
            hexv  = 8'h00;
            phase = PH_HEX2_DONE;
          end
        end
        PH_HEX2: begin
          d = nibble_of(c);
          if (d >= 0) hexv = {hexv[3:0], 4'(d)};
          phase = PH_CR;
        end
        PH_HEX2_DONE: phase = PH_CR;
        PH_CR: begin
          if (c == CH_CR) phase = PH_LF;
          else begin
            push_report(ST_BADTAIL);
            phase = PH_HUNT;
            return;
          end
        end
        PH_LF: begin
          if (c == CH_LF) push_report(xsum == hexv ? ST_OK : ST_MISMATCH);
          else push_report(ST_BADTAIL);
          phase = PH_HUNT;
          return;
        end
        default: begin
          phase = PH_HUNT;
          return;
        end
      endcase
      if (count >= max_len) begin
        count = 8'(max_len);
        push_report(ST_TOOLONG);
        phase = PH_HUNT;
      end
    endfunction

    function void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: report expected none, actual status %0d kind %0d sums %0d/%0d length %0d",
                 $time, got.status, got.sentence_kind, got.computed_sum, got.received_sum,
                 got.sentence_length);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      reports++;
      status_seen[want.status]++;
      check_field("status", want.status, got.status);
      check_field("sentence_kind", want.sentence_kind, got.sentence_kind);
      check_field("computed_sum", want.computed_sum, got.computed_sum);
      check_field("received_sum", want.received_sum, got.received_sum);
      check_field("sentence_length", want.sentence_length, got.sentence_length);
    endfunction
  endclass

endpackage

// File: sim/nmea_sentence_framer_top_tb.sv
// Testbench for the NMEA sentence framer: byte streams with random framing, checked per report.
module nmea_sentence_framer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nsf_pkg::*;
  import nsf_tb_pkg::*;

  localparam int FRAME_MAX   = MAX_SENTENCE_DEF;
  localparam int BYTE_TARGET = 1100;
  localparam int HOLD_CYCLES = 80;
  localparam int FLOOD_BYTES = 30;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_status;
  logic [2:0] out_sentence_kind;
  logic [7:0] out_computed_sum;
  logic [7:0] out_received_sum;
  logic [7:0] out_sentence_length;

  sentence_tracker board;
  int              bytes_sent;
  int              burst_left;
  bit              hold_req;

  nmea_sentence_framer_top #(.MAX_SENTENCE(FRAME_MAX)) i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_report({out_status, out_sentence_kind, out_computed_sum,
                          out_received_sum, out_sentence_length});
    if (rst_n && in_valid && !in_stall) board.accept_byte(in_data_byte);
  end

  initial begin : receiver
    int seg_left;
    int seg_mode;
    out_stall <= 1'b0;
    seg_left = 0;
    seg_mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(4, 40);
        end
        seg_left--;
        case (seg_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          2: out_stall <= seg_left[0];
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    else begin
      pause($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_for_reports();
    pause(1);
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + n;
    return (lower ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  task automatic send_sentence();
    logic [7:0] q[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         hdr_sel;
    int         near;
    int         pos;
    int         shape;
    int         body_len;
    int         sum_mode;
    int         tail_mode;
    bit         lower;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(0, 255));
        q.push_back(b == CH_DOLLAR ? 8'h00 : b);
      end
    end
    q.push_back(CH_DOLLAR);
    sum     = 8'h00;
    hdr_sel = $urandom_range(0, NUM_KINDS + 1);
    near    = $urandom_range(0, NUM_KINDS - 1);
    pos     = $urandom_range(0, HDR_LEN - 1);
    for (int i = 0; i < HDR_LEN; i++) begin
      if (hdr_sel < NUM_KINDS) b = KIND_NAMES[hdr_sel][i];
      else if (hdr_sel == NUM_KINDS || i == pos) b = 8'($urandom_range(8'h41, 8'h5A));
      else b = KIND_NAMES[near][i];
      sum ^= b;
      q.push_back(b);
    end
    shape    = $urandom_range(0, 99);
    body_len = (shape < 3) ? $urandom_range(FRAME_MAX - 8, FRAME_MAX + 12)
                           : $urandom_range(0, 24);
    repeat (body_len) begin
      b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(8'h20, 8'h7E));
      if (b == CH_DOLLAR || b == CH_STAR) b = 8'h2C;
      sum ^= b;
      q.push_back(b);
    end
    // checksum and tail unless cut short; a cut sentence is ended by the next sentence's start
    if (shape < 3 || shape >= 9) begin
      q.push_back(CH_STAR);
      sum_mode = $urandom_range(0, 9);
      lower    = 1'($urandom_range(0, 1));
      if (sum_mode == 7) sum ^= 8'($urandom_range(1, 255));
      case (sum_mode)
        8: begin
          q.push_back(8'($urandom_range(0, 255)));
          q.push_back(8'($urandom_range(0, 255)));
        end
        9: q.push_back(hex_char(sum[7:4], lower));
        default: begin
          q.push_back(hex_char(sum[7:4], lower));
          q.push_back(hex_char(sum[3:0], lower));
        end
      endcase
      tail_mode = $urandom_range(0, 9);
      q.push_back(tail_mode == 8 ? 8'($urandom_range(0, 255)) : CH_CR);
      q.push_back(tail_mode == 9 ? 8'($urandom_range(0, 255)) : CH_LF);
    end
    foreach (q[i]) send_byte(q[i]);
  endtask

  initial begin : stimulus
    bit flooded;
    bit drained;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    board      = new(FRAME_MAX);
    bytes_sent = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    flooded    = 1'b0;
    drained    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$GPGGA*56");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text("$GP$GPVTG*G1");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text("$*5XQ");
    wait_for_reports();

    while (bytes_sent < BYTE_TARGET) begin
      if (!flooded && bytes_sent >= 400) begin
        flooded  = 1'b1;
        hold_req = 1'b1;
        repeat (FLOOD_BYTES) send_byte(CH_DOLLAR);
      end
      if (!drained && bytes_sent >= 750) begin
        drained = 1'b1;
        wait_for_reports();
      end
      send_sentence();
    end
    wait_for_reports();
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes, checked %0d sentence reports", bytes_sent, board.reports);
    $display("By status: ok %0d, bad checksum %0d, restarted %0d, bad tail %0d, overlong %0d",
             board.status_seen[ST_OK], board.status_seen[ST_MISMATCH],
             board.status_seen[ST_CUT], board.status_seen[ST_BADTAIL],
             board.status_seen[ST_TOOLONG]);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #500us;
    $display("FAILURE");
    $finish;
  end

endmodule
